FILE: design/pcc_pkg.sv
// Shared types, constants and the edge test helper for the polygon segment crossing counter.
package pcc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int VERT_W  = 2 * COORD_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        logic [1:0] func;
        coord_t     vertex_x;
        coord_t     vertex_y;
        coord_t     seg_start_x;
        coord_t     seg_start_y;
        coord_t     seg_end_x;
        coord_t     seg_end_y;
    } cmd_t;

    typedef struct packed {
        logic             vertex_overflow;
        logic             any_crossing;
        logic [CNT_W-1:0] crossing_count;
    } result_t;

    // Numerator accepted when it lies inside [0, den] on the side of den's sign.
    function automatic logic nom_ok(input sum_t nom, input sum_t den);
        logic ok;
        ok = 1'b1;
        if (nom < 0 && (den > 0 || nom < den))
        begin
            ok = 1'b0;
        end
        if (nom > 0 && (den < 0 || nom > den))
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

FILE: design/pcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/pcc_front.sv
// Front end: take input words, drop unused function codes, hold one command for the queue.
module pcc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output pcc_pkg::cmd_t cmd
);
    import pcc_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_reg;
    logic accept;

    assign s_tready = !hold_valid_reg || cmd_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (cmd_valid && cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next = (s_tuser != FUNC_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg.func        <= s_tuser;
            hold_reg.vertex_x    <= s_tdata[15:0];
            hold_reg.vertex_y    <= s_tdata[31:16];
            hold_reg.seg_start_x <= s_tdata[47:32];
            hold_reg.seg_start_y <= s_tdata[63:48];
            hold_reg.seg_end_x   <= s_tdata[79:64];
            hold_reg.seg_end_y   <= s_tdata[95:80];
        end
    end

    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

endmodule

FILE: design/pcc_queue.sv
// Short command queue between front end and back end.
module pcc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  pcc_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output pcc_pkg::cmd_t pop_cmd
);
    import pcc_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/pcc_back.sv
// Back end: vertex store, edge walk, pipelined sign test and result register.
module pcc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  pcc_pkg::cmd_t    cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output pcc_pkg::result_t res
);
    import pcc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] total_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] walk_reg;
    logic [CNT_W-1:0] count_reg;

    coord_t ax_reg;
    coord_t ay_reg;
    diff_t  s2x_reg;
    diff_t  s2y_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [VERT_W-1:0] rd_data;
    coord_t            cur_x;
    coord_t            cur_y;

    logic   rd_valid_reg;
    logic   rd_first_reg;
    logic   rd_last_reg;
    coord_t prev_x_reg;
    coord_t prev_y_reg;

    logic  e1_valid_reg;
    logic  e1_last_reg;
    diff_t dx_reg;
    diff_t dy_reg;
    diff_t s1x_reg;
    diff_t s1y_reg;

    logic  e2_valid_reg;
    logic  e2_last_reg;
    prod_t m1_reg;
    prod_t m2_reg;
    prod_t m3_reg;
    prod_t m4_reg;
    prod_t m5_reg;
    prod_t m6_reg;

    logic e3_valid_reg;
    logic e3_last_reg;
    sum_t snom_reg;
    sum_t tnom_reg;
    sum_t den_reg;

    logic             hit;
    logic [CNT_W-1:0] count_sum;
    logic             accept;
    logic             walk_end;

    logic    out_valid_reg;
    result_t out_reg;

    // A query waits until the previous result has been taken.
    assign cmd_ready = (state_reg == ST_IDLE) && (cmd.func != FUNC_QUERY || !out_valid_reg);
    assign accept    = cmd_valid && cmd_ready;
    assign walk_end  = (walk_reg == total_reg);

    assign wr_en   = accept && (cmd.func == FUNC_APPEND) && (total_reg < CNT_W'(MAX_VERTICES));
    assign wr_addr = total_reg[IDX_W-1:0];
    assign rd_en   = (state_reg == ST_WALK);
    // The extra read at the end wraps to vertex 0 for the closing edge.
    assign rd_addr = walk_end ? '0 : walk_reg[IDX_W-1:0];

    pcc_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({cmd.vertex_y, cmd.vertex_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cur_x = rd_data[COORD_W-1:0];
    assign cur_y = rd_data[VERT_W-1:COORD_W];

    assign hit       = nom_ok(snom_reg, den_reg) && nom_ok(tnom_reg, den_reg);
    assign count_sum = count_reg + CNT_W'(hit);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.func == FUNC_QUERY && total_reg != '0)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (e3_valid_reg && e3_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            walk_reg      <= '0;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                case (cmd.func)
                    FUNC_CLEAR:
                    begin
                        total_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end
                    FUNC_APPEND:
                    begin
                        if (wr_en)
                        begin
                            total_reg <= total_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    FUNC_QUERY:
                    begin
                        walk_reg  <= '0;
                        count_reg <= '0;
                        if (total_reg == '0)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_WALK)
            begin
                walk_reg <= walk_reg + 1'b1;
            end

            rd_valid_reg <= rd_en;
            e1_valid_reg <= rd_valid_reg && !rd_first_reg;
            e2_valid_reg <= e1_valid_reg;
            e3_valid_reg <= e2_valid_reg;

            if (e3_valid_reg)
            begin
                count_reg <= count_sum;
                if (e3_last_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.func == FUNC_QUERY)
        begin
            ax_reg  <= cmd.seg_start_x;
            ay_reg  <= cmd.seg_start_y;
            s2x_reg <= DIFF_W'(cmd.seg_end_x) - DIFF_W'(cmd.seg_start_x);
            s2y_reg <= DIFF_W'(cmd.seg_end_y) - DIFF_W'(cmd.seg_start_y);
            out_reg.crossing_count  <= '0;
            out_reg.any_crossing    <= 1'b0;
            out_reg.vertex_overflow <= ovf_reg;
        end

        rd_first_reg <= (walk_reg == '0);
        rd_last_reg  <= walk_end;

        if (rd_valid_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end

        // Stage 1: edge vector and offset from the segment start.
        e1_last_reg <= rd_last_reg;
        dx_reg      <= DIFF_W'(prev_x_reg) - DIFF_W'(ax_reg);
        dy_reg      <= DIFF_W'(prev_y_reg) - DIFF_W'(ay_reg);
        s1x_reg     <= DIFF_W'(cur_x) - DIFF_W'(prev_x_reg);
        s1y_reg     <= DIFF_W'(cur_y) - DIFF_W'(prev_y_reg);

        // Stage 2: the six cross products.
        e2_last_reg <= e1_last_reg;
        m1_reg      <= s1y_reg * dx_reg;
        m2_reg      <= s1x_reg * dy_reg;
        m3_reg      <= s2x_reg * dy_reg;
        m4_reg      <= s2y_reg * dx_reg;
        m5_reg      <= s2x_reg * s1y_reg;
        m6_reg      <= s1x_reg * s2y_reg;

        // Stage 3: numerators and denominator.
        e3_last_reg <= e2_last_reg;
        snom_reg    <= SUM_W'(m2_reg) - SUM_W'(m1_reg);
        tnom_reg    <= SUM_W'(m3_reg) - SUM_W'(m4_reg);
        den_reg     <= SUM_W'(m6_reg) - SUM_W'(m5_reg);

        if (e3_valid_reg && e3_last_reg)
        begin
            out_reg.crossing_count <= count_sum;
            out_reg.any_crossing   <= (count_sum != '0);
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: design/polygon_segment_crossing_count_top.sv
// Top level of the polygon segment crossing counter: front end, command queue, back end.
// A query over n stored vertices makes n + 1 store reads, one vertex per cycle plus a wrap
// read for the closing edge, then drains the test pipeline and registers the result word.
// The back end takes no new command while a walk is under way, and no new query until
// the previous result word has been taken.
// Reset: asynchronous, active low; clears vertex count, overflow flag, queue and handshakes.
// Vertex store contents stay undefined until written and get no clearing pass.
module polygon_segment_crossing_count_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // vertex_x, vertex_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y (16 bits each)
    input  logic [95:0] s_tdata,
    // func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // crossing_count [8:0], any_crossing [9], vertex_overflow [10], zero fill above
    output logic [15:0] m_tdata
);
    import pcc_pkg::*;

    logic    front_valid;
    logic    front_ready;
    cmd_t    front_cmd;
    logic    queue_valid;
    logic    queue_ready;
    cmd_t    queue_cmd;
    result_t result;

    // Accept and classify input words; unused function codes are dropped here.
    pcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // Decouple the front end from the edge walk so loads keep flowing during a query.
    pcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    // Execute commands in order: store vertices, walk edges, hold the result word.
    pcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (result)
    );

    assign m_tdata = {5'b0, result.vertex_overflow, result.any_crossing,
                      result.crossing_count};

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the polygon segment crossing counter top level.
module testbench;

    import pcc_pkg::*;

    // One input word as the sender sees it; func travels on tuser, the rest on tdata.
    typedef struct {
        logic [1:0] func;
        coord_t     vertex_x;
        coord_t     vertex_y;
        coord_t     seg_start_x;
        coord_t     seg_start_y;
        coord_t     seg_end_x;
        coord_t     seg_end_y;
    } word_t;

    localparam int RANDOM_ITEMS = 750;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    polygon_segment_crossing_count_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // vertex_x, vertex_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y (16 bits each)
        .s_tdata  (s_tdata),
        // func
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // crossing_count [8:0], any_crossing [9], vertex_overflow [10], zero fill above
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Predicted polygon: our own copy of the vertex store, count and sticky overflow.
    int      poly_x [MAX_VERTICES];
    int      poly_y [MAX_VERTICES];
    int      poly_len      = 0;
    bit      poly_overflow = 1'b0;

    word_t   pending_words [$];
    result_t expected_tallies [$];

    int      words_queued   = 0;
    int      words_accepted = 0;
    int      item_count     = 0;
    int      error_count    = 0;

    // Handshake bookkeeping shared between the rising-edge and falling-edge processes.
    word_t   cur_word;
    bit      holding      = 1'b0;
    bit      word_taken   = 1'b0;
    bit      result_taken = 1'b0;
    int      gap_left     = 0;
    int      stall_left   = 0;
    bit      tx_quiet     = 1'b0;
    bit      rx_quiet     = 1'b0;

    result_t got_tally;
    result_t want_tally;

    // A line parameter numerator is valid when it lies between 0 and den, on den's side.
    function automatic bit param_in_range(longint num, longint den);
        if (num < 0 && (den > 0 || num < den))
        begin
            return 1'b0;
        end
        if (num > 0 && (den < 0 || num > den))
        begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Exact integer intersection test of edge P0-P1 against segment A-B.
    function automatic bit edge_hits_segment(longint p0x, longint p0y, longint p1x, longint p1y,
                                             longint ax, longint ay, longint bx, longint by);
        longint s1x, s1y, s2x, s2y, dx, dy, snum, tnum, den;
        s1x  = p1x - p0x;
        s1y  = p1y - p0y;
        s2x  = bx - ax;
        s2y  = by - ay;
        dx   = p0x - ax;
        dy   = p0y - ay;
        snum = -s1y * dx + s1x * dy;
        tnum = s2x * dy - s2y * dx;
        den  = -s2x * s1y + s1x * s2y;
        return param_in_range(snum, den) && param_in_range(tnum, den);
    endfunction

    // Advance the predicted polygon by one accepted word; queries leave an expected tally.
    task automatic apply_word(input word_t w);
        int      hits;
        int      j;
        result_t tally;
        case (w.func)
            FUNC_CLEAR:
            begin
                poly_len      = 0;
                poly_overflow = 1'b0;
            end
            FUNC_APPEND:
            begin
                if (poly_len < MAX_VERTICES)
                begin
                    poly_x[poly_len] = w.vertex_x;
                    poly_y[poly_len] = w.vertex_y;
                    poly_len++;
                end
                else
                begin
                    poly_overflow = 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                hits = 0;
                // Walk every edge, the closing edge from the last vertex back to the first too.
                for (int i = 0; i < poly_len; i++)
                begin
                    j = (i + 1 == poly_len) ? 0 : i + 1;
                    if (edge_hits_segment(poly_x[i], poly_y[i], poly_x[j], poly_y[j],
                                          w.seg_start_x, w.seg_start_y,
                                          w.seg_end_x, w.seg_end_y))
                    begin
                        hits++;
                    end
                end
                tally.crossing_count  = hits[CNT_W-1:0];
                tally.any_crossing    = (hits != 0);
                tally.vertex_overflow = poly_overflow;
                expected_tallies.push_back(tally);
            end
            default:
            begin
                // Unused func code: drop the word.
            end
        endcase
    endtask

    // Fill every coordinate at random so the fields a func ignores still toggle.
    function automatic word_t random_word(logic [1:0] func);
        word_t w;
        w.func        = func;
        w.vertex_x    = coord_t'($urandom);
        w.vertex_y    = coord_t'($urandom);
        w.seg_start_x = coord_t'($urandom);
        w.seg_start_y = coord_t'($urandom);
        w.seg_end_x   = coord_t'($urandom);
        w.seg_end_y   = coord_t'($urandom);
        return w;
    endfunction

    // Style 0: full range; 1: a tight grid that makes touching and collinear edges common;
    // 2: values at and near the range limits, and around zero.
    function automatic coord_t pick_coord(int style);
        case (style)
            1:       return coord_t'($urandom_range(0, 16)) - coord_t'(8);
            2:
            begin
                case ($urandom_range(0, 5))
                    0:       return coord_t'(-32768);
                    1:       return coord_t'(32767);
                    2:       return coord_t'(-32767);
                    3:       return coord_t'(-1);
                    4:       return coord_t'(1);
                    default: return coord_t'(0);
                endcase
            end
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic queue_word(input word_t w);
        pending_words.push_back(w);
        words_queued++;
        if (w.func != FUNC_NONE)
        begin
            item_count++;
        end
    endtask

    task automatic queue_clear();
        queue_word(random_word(FUNC_CLEAR));
    endtask

    task automatic queue_append(input coord_t x, input coord_t y);
        word_t w;
        w          = random_word(FUNC_APPEND);
        w.vertex_x = x;
        w.vertex_y = y;
        queue_word(w);
    endtask

    task automatic queue_query(input coord_t ax, input coord_t ay,
                               input coord_t bx, input coord_t by);
        word_t w;
        w             = random_word(FUNC_QUERY);
        w.seg_start_x = ax;
        w.seg_start_y = ay;
        w.seg_end_x   = bx;
        w.seg_end_y   = by;
        queue_word(w);
    endtask

    // Accept on the rising edge: update the prediction for taken input words and
    // check each taken result word against the oldest expected tally.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                result_taken = 1'b1;
                got_tally    = m_tdata[10:0];
                if (expected_tallies.size() == 0)
                begin
                    $error("result word with no query waiting: m_tdata=%h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want_tally = expected_tallies.pop_front();
                    if (got_tally.crossing_count !== want_tally.crossing_count)
                    begin
                        $error("crossing_count: expected %0d, actual %0d",
                               want_tally.crossing_count, got_tally.crossing_count);
                        error_count++;
                    end
                    if (got_tally.any_crossing !== want_tally.any_crossing)
                    begin
                        $error("any_crossing: expected %0b, actual %0b",
                               want_tally.any_crossing, got_tally.any_crossing);
                        error_count++;
                    end
                    if (got_tally.vertex_overflow !== want_tally.vertex_overflow)
                    begin
                        $error("vertex_overflow: expected %0b, actual %0b",
                               want_tally.vertex_overflow, got_tally.vertex_overflow);
                        error_count++;
                    end
                    if (m_tdata[15:11] !== 5'd0)
                    begin
                        $error("zero fill: expected %0h, actual %0h", 5'd0, m_tdata[15:11]);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_word(cur_word);
                words_accepted++;
                word_taken = 1'b1;
            end
        end
    end

    // Sender: on the falling edge drop a taken word, wait out its drawn gap, then present
    // the next pending word. tvalid gets exactly one assignment per edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (word_taken)
            begin
                holding    = 1'b0;
                word_taken = 1'b0;
            end
            if (!holding && gap_left > 0)
            begin
                gap_left--;
            end
            else if (!holding && pending_words.size() > 0)
            begin
                cur_word = pending_words.pop_front();
                holding  = 1'b1;
                // Switch between idling and back-to-back stretches now and then.
                if ($urandom_range(0, 31) == 0)
                begin
                    tx_quiet = !tx_quiet;
                end
                gap_left = tx_quiet ? 0 : $urandom_range(0, 7);
                s_tdata <= {cur_word.seg_end_y, cur_word.seg_end_x,
                            cur_word.seg_start_y, cur_word.seg_start_x,
                            cur_word.vertex_y, cur_word.vertex_x};
                s_tuser <= cur_word.func;
            end
            s_tvalid <= holding;
        end
    end

    // Receiver: after each taken result word, stall tready for a drawn number of cycles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                if ($urandom_range(0, 31) == 0)
                begin
                    rx_quiet = !rx_quiet;
                end
                stall_left = rx_quiet ? 0 : $urandom_range(0, 7);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Hard limit on the run, far above the slowest legal schedule.
    initial
    begin
        #10_000_000;
        $display("** polygon_segment_crossing_count_top: FAILED **");
        $finish;
    end

    initial
    begin
        int     style;
        int     n_vertices;
        int     n_queries;
        word_t  w;

        // Directed: empty polygon, queried with extreme corners.
        queue_query(-32768, -32768, 32767, 32767);
        // Single vertex: one zero-length edge, hit by a segment through it, missed by another.
        queue_append(5, 5);
        queue_query(0, 0, 10, 10);
        queue_query(0, 0, 10, 0);
        // Two vertices at the range corners: both edges lie on one line.
        queue_clear();
        queue_append(-32768, -32768);
        queue_append(32767, 32767);
        queue_query(-32768, 32767, 32767, -32768);
        // Triangle: collinear but disjoint, parallel, plain crossing, touching a vertex.
        queue_clear();
        queue_append(0, 0);
        queue_append(10, 0);
        queue_append(0, 10);
        queue_query(20, 0, 30, 0);
        queue_query(20, 20, 30, 20);
        queue_query(-5, 3, 20, 3);
        queue_query(10, 0, 10, -10);
        // Unused func code with every data bit set.
        w             = random_word(FUNC_NONE);
        w.vertex_x    = '1;
        w.vertex_y    = '1;
        w.seg_start_x = '1;
        w.seg_start_y = '1;
        w.seg_end_x   = '1;
        w.seg_end_y   = '1;
        queue_word(w);
        // Extreme triangle, crossed by a diagonal and queried with a zero-length segment inside it.
        queue_clear();
        queue_append(32767, -32768);
        queue_append(-32768, 32767);
        queue_append(32767, 32767);
        queue_query(-32768, -32768, 32767, 32767);
        queue_query(0, 0, 0, 0);

        // Fill the store past capacity: the extra appends drop and raise the sticky flag,
        // which a clear then lowers.
        queue_clear();
        for (int i = 0; i < MAX_VERTICES + 2; i++)
        begin
            queue_append(pick_coord(0), pick_coord(0));
        end
        queue_query(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0));
        queue_query(pick_coord(2), pick_coord(2), pick_coord(2), pick_coord(2));
        queue_query(pick_coord(1), pick_coord(1), pick_coord(0), pick_coord(0));
        queue_clear();
        queue_query(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0));

        // Random polygons with queries; skip the clear now and then so appends pile up,
        // and mix in unused-code noise.
        while (item_count < RANDOM_ITEMS)
        begin
            style = $urandom_range(0, 2);
            if ($urandom_range(0, 4) != 0)
            begin
                queue_clear();
            end
            n_vertices = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 12);
            for (int i = 0; i < n_vertices; i++)
            begin
                queue_append(pick_coord(style), pick_coord(style));
            end
            n_queries = $urandom_range(1, 5);
            for (int i = 0; i < n_queries; i++)
            begin
                queue_query(pick_coord(style), pick_coord(style),
                            pick_coord(style), pick_coord(style));
            end
            if ($urandom_range(0, 4) == 0)
            begin
                queue_word(random_word(FUNC_NONE));
            end
        end

        // Hold reset, then release it on a falling edge.
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken and every tally to come back, then let the
        // longest query latency pass so a stray result word still gets caught.
        while (words_accepted < words_queued)
        begin
            @(posedge clk);
        end
        while (expected_tallies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (MAX_VERTICES + 40) @(posedge clk);

        if (error_count == 0)
        begin
            $display("** polygon_segment_crossing_count_top: PASSED **");
        end
        else
        begin
            $display("** polygon_segment_crossing_count_top: FAILED **");
        end
        $finish;
    end

endmodule
